// ===== sv/json_string_unescape_utf8_assert.svh =====
// ----------------------------------------------------------------------------
// JSON string unescaper: assertion macros
// Concurrent assertion wrappers. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define JSU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define JSU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper: package
// Request and result types, decoder state, codes and UTF-8 helpers.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// one text request
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} text_item_t;

	// one result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] result_kind;
		logic [2:0] error_code;
		logic       last_of_run;
	} result_item_t;

	// results one request can cause
	localparam int MaxResults = 4;
	localparam int CountW     = $clog2(MaxResults + 1);
	localparam int IdxW       = $clog2(MaxResults);

	// all results of one request, in order
	typedef struct packed {
		logic [CountW-1:0]                count;
		result_item_t [MaxResults-1:0]    item;
	} result_group_t;

	// result kinds
	localparam logic [1:0] KIND_DATA     = 2'd0;
	localparam logic [1:0] KIND_COMPLETE = 2'd1;
	localparam logic [1:0] KIND_ERROR    = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_EXP_QUOTE    = 3'd1;
	localparam logic [2:0] ERR_UNTERMINATED = 3'd2;
	localparam logic [2:0] ERR_UNTERM_ESC   = 3'd3;
	localparam logic [2:0] ERR_BAD_ESC      = 3'd4;
	localparam logic [2:0] ERR_TRUNC_HEX    = 3'd5;
	localparam logic [2:0] ERR_BAD_HEX      = 3'd6;
	localparam logic [2:0] ERR_CONTROL      = 3'd7;

	// characters
	localparam logic [7:0] CHR_QUOTE  = 8'h22;
	localparam logic [7:0] CHR_BSLASH = 8'h5C;
	localparam logic [7:0] CHR_SLASH  = 8'h2F;
	localparam logic [7:0] CHR_SPACE  = 8'h20;
	localparam logic [7:0] CHR_B      = 8'h62;
	localparam logic [7:0] CHR_F      = 8'h66;
	localparam logic [7:0] CHR_N      = 8'h6E;
	localparam logic [7:0] CHR_R      = 8'h72;
	localparam logic [7:0] CHR_T      = 8'h74;
	localparam logic [7:0] CHR_U      = 8'h75;
	localparam logic [7:0] CHR_BS     = 8'h08;
	localparam logic [7:0] CHR_FF     = 8'h0C;
	localparam logic [7:0] CHR_LF     = 8'h0A;
	localparam logic [7:0] CHR_CR     = 8'h0D;
	localparam logic [7:0] CHR_TAB    = 8'h09;
	localparam logic [7:0] CHR_0      = 8'h30;
	localparam logic [7:0] CHR_9      = 8'h39;
	localparam logic [7:0] CHR_LA     = 8'h61;
	localparam logic [7:0] CHR_LF_HEX = 8'h66;
	localparam logic [7:0] CHR_UA     = 8'h41;
	localparam logic [7:0] CHR_UF     = 8'h46;

	// surrogates and code points
	localparam logic [15:0] SURR_HI_MIN = 16'hD800;
	localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
	localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
	localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
	localparam logic [20:0] CP_SUPP     = 21'h10000;
	localparam logic [20:0] CP_REPLACE  = 21'h0FFFD;
	localparam logic [20:0] CP_2BYTE    = 21'h00800;
	localparam logic [20:0] CP_1BYTE    = 21'h00080;

	// UTF-8 marks
	localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
	localparam logic [7:0] UTF8_CONT  = 8'h80;

	// decoder modes
	typedef enum logic [6:0] {
		MODE_IDLE      = 7'b0000001,
		MODE_STR       = 7'b0000010,
		MODE_ESC       = 7'b0000100,
		MODE_HEX_HI    = 7'b0001000,
		MODE_AFT_HI    = 7'b0010000,
		MODE_AFT_HI_BS = 7'b0100000,
		MODE_HEX_LO    = 7'b1000000
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  hex_cnt;
		logic [15:0] high_unit;
		logic [15:0] low_unit;
	} decode_state_t;

	localparam decode_state_t IdleState = '{
		mode: MODE_IDLE, hex_cnt: 2'd0, high_unit: 16'd0, low_unit: 16'd0
	};

	// append one result to a group
	function automatic result_group_t push_result(input result_group_t g,
		input logic [7:0] b, input logic [1:0] kind, input logic [2:0] code);
		result_group_t r;
		r = g;
		r.item[g.count[IdxW-1:0]] = '{out_byte: b, result_kind: kind,
			error_code: code, last_of_run: 1'b0};
		r.count = g.count + CountW'(1);
		return r;
	endfunction

	// append the UTF-8 bytes of a code point
	function automatic result_group_t push_utf8(input result_group_t g,
		input logic [20:0] cp);
		result_group_t r;
		r = g;
		if (cp < CP_1BYTE) begin
			r = push_result(r, cp[7:0], KIND_DATA, ERR_NONE);
		end else if (cp < CP_2BYTE) begin
			r = push_result(r, UTF8_LEAD2 | {3'd0, cp[10:6]}, KIND_DATA, ERR_NONE);
			r = push_result(r, UTF8_CONT | {2'd0, cp[5:0]}, KIND_DATA, ERR_NONE);
		end else if (cp < CP_SUPP) begin
			r = push_result(r, UTF8_LEAD3 | {4'd0, cp[15:12]}, KIND_DATA, ERR_NONE);
			r = push_result(r, UTF8_CONT | {2'd0, cp[11:6]}, KIND_DATA, ERR_NONE);
			r = push_result(r, UTF8_CONT | {2'd0, cp[5:0]}, KIND_DATA, ERR_NONE);
		end else begin
			r = push_result(r, UTF8_LEAD4 | {5'd0, cp[20:18]}, KIND_DATA, ERR_NONE);
			r = push_result(r, UTF8_CONT | {2'd0, cp[17:12]}, KIND_DATA, ERR_NONE);
			r = push_result(r, UTF8_CONT | {2'd0, cp[11:6]}, KIND_DATA, ERR_NONE);
			r = push_result(r, UTF8_CONT | {2'd0, cp[5:0]}, KIND_DATA, ERR_NONE);
		end
		return r;
	endfunction

	// hex digit value; bit 4 set when the byte is a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c inside {[CHR_0:CHR_9]}) begin
			d = c - CHR_0;
			return {1'b1, d[3:0]};
		end else if (c inside {[CHR_LA:CHR_LF_HEX]}) begin
			d = c - CHR_LA + 8'd10;
			return {1'b1, d[3:0]};
		end else if (c inside {[CHR_UA:CHR_UF]}) begin
			d = c - CHR_UA + 8'd10;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

endpackage

// ===== sv/jsu_text_if.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper: text channel
// Valid/ready channel carrying one text byte or the end marker.
// ----------------------------------------------------------------------------
interface jsu_text_if;
	logic                 valid;
	logic                 ready;
	jsu_pkg::text_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/jsu_result_if.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper: result channel
// Valid/ready channel carrying one decoded byte, completion or error.
// ----------------------------------------------------------------------------
interface jsu_result_if;
	logic                   valid;
	logic                   ready;
	jsu_pkg::result_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper: decoder
// Next decoder state and the full result group for one text request.
// ----------------------------------------------------------------------------
module jsu_decode (
	input  jsu_pkg::decode_state_t state,
	input  jsu_pkg::text_item_t    item,
	output jsu_pkg::decode_state_t state_nxt,
	output jsu_pkg::result_group_t group
);
	import jsu_pkg::*;

	always_comb begin
		decode_state_t nxt;
		result_group_t grp;
		logic [7:0]    b;
		logic [4:0]    hx;
		logic [15:0]   unit;
		logic [20:0]   cp;
		logic          tail_str;
		logic          tail_esc;
		logic          do_err;
		logic [2:0]    err_code;
		logic          done;

		nxt      = state;
		grp      = '0;
		b        = item.in_byte;
		hx       = hex_value(b);
		unit     = 16'd0;
		cp       = CP_REPLACE;
		tail_str = 1'b0;
		tail_esc = 1'b0;
		do_err   = 1'b0;
		err_code = ERR_NONE;
		done     = 1'b0;

		if (item.end_of_text) begin
			// end of text: the mode decides which error
			do_err = 1'b1;
			case (state.mode)
				MODE_STR: begin
					err_code = ERR_UNTERMINATED;
				end
				MODE_ESC: begin
					err_code = ERR_UNTERM_ESC;
				end
				MODE_HEX_HI, MODE_HEX_LO: begin
					err_code = ERR_TRUNC_HEX;
				end
				MODE_AFT_HI: begin
					grp      = push_utf8(grp, CP_REPLACE);
					err_code = ERR_UNTERMINATED;
				end
				MODE_AFT_HI_BS: begin
					grp      = push_utf8(grp, CP_REPLACE);
					err_code = ERR_UNTERM_ESC;
				end
				default: begin
					err_code = ERR_EXP_QUOTE;
				end
			endcase
		end else begin
			case (state.mode)
				MODE_STR: begin
					tail_str = 1'b1;
				end
				MODE_ESC: begin
					tail_esc = 1'b1;
				end
				MODE_HEX_HI: begin
					if (!hx[4]) begin
						do_err   = 1'b1;
						err_code = ERR_BAD_HEX;
					end else begin
						unit          = {state.high_unit[11:0], hx[3:0]};
						nxt.high_unit = unit;
						if (state.hex_cnt == 2'd3) begin
							nxt.hex_cnt = 2'd0;
							nxt.mode    = MODE_STR;
							if (unit inside {[SURR_HI_MIN:SURR_HI_MAX]}) begin
								nxt.mode = MODE_AFT_HI;
							end else if (unit inside {[SURR_LO_MIN:SURR_LO_MAX]}) begin
								grp = push_utf8(grp, CP_REPLACE);
							end else begin
								grp = push_utf8(grp, {5'd0, unit});
							end
						end else begin
							nxt.hex_cnt = state.hex_cnt + 2'd1;
						end
					end
				end
				MODE_AFT_HI: begin
					if (b == CHR_BSLASH) begin
						nxt.mode = MODE_AFT_HI_BS;
					end else begin
						grp      = push_utf8(grp, CP_REPLACE);
						tail_str = 1'b1;
					end
				end
				MODE_AFT_HI_BS: begin
					if (b == CHR_U) begin
						nxt.mode     = MODE_HEX_LO;
						nxt.hex_cnt  = 2'd0;
						nxt.low_unit = 16'd0;
					end else begin
						grp      = push_utf8(grp, CP_REPLACE);
						tail_esc = 1'b1;
					end
				end
				MODE_HEX_LO: begin
					if (!hx[4]) begin
						do_err   = 1'b1;
						err_code = ERR_BAD_HEX;
					end else begin
						unit         = {state.low_unit[11:0], hx[3:0]};
						nxt.low_unit = unit;
						if (state.hex_cnt == 2'd3) begin
							nxt.hex_cnt = 2'd0;
							nxt.mode    = MODE_STR;
							// high unit is D800..DBFF here, so its offset is its low ten bits
							if (unit inside {[SURR_LO_MIN:SURR_LO_MAX]}) begin
								cp = CP_SUPP + {1'b0, state.high_unit[9:0], unit[9:0]};
							end
							grp = push_utf8(grp, cp);
						end else begin
							nxt.hex_cnt = state.hex_cnt + 2'd1;
						end
					end
				end
				default: begin
					// idle: only the opening quote is welcome
					if (b == CHR_QUOTE) begin
						nxt.mode    = MODE_STR;
						nxt.hex_cnt = 2'd0;
					end else begin
						do_err   = 1'b1;
						err_code = ERR_EXP_QUOTE;
					end
				end
			endcase
		end

		// ordinary string byte
		if (tail_str) begin
			nxt.mode = MODE_STR;
			if (b == CHR_QUOTE) begin
				done = 1'b1;
			end else if (b == CHR_BSLASH) begin
				nxt.mode = MODE_ESC;
			end else if (b < CHR_SPACE) begin
				do_err   = 1'b1;
				err_code = ERR_CONTROL;
			end else begin
				grp = push_result(grp, b, KIND_DATA, ERR_NONE);
			end
		end

		// byte after a backslash
		if (tail_esc) begin
			nxt.mode = MODE_STR;
			case (b)
				CHR_QUOTE:  grp = push_result(grp, CHR_QUOTE, KIND_DATA, ERR_NONE);
				CHR_BSLASH: grp = push_result(grp, CHR_BSLASH, KIND_DATA, ERR_NONE);
				CHR_SLASH:  grp = push_result(grp, CHR_SLASH, KIND_DATA, ERR_NONE);
				CHR_B:      grp = push_result(grp, CHR_BS, KIND_DATA, ERR_NONE);
				CHR_F:      grp = push_result(grp, CHR_FF, KIND_DATA, ERR_NONE);
				CHR_N:      grp = push_result(grp, CHR_LF, KIND_DATA, ERR_NONE);
				CHR_R:      grp = push_result(grp, CHR_CR, KIND_DATA, ERR_NONE);
				CHR_T:      grp = push_result(grp, CHR_TAB, KIND_DATA, ERR_NONE);
				CHR_U: begin
					nxt.mode      = MODE_HEX_HI;
					nxt.hex_cnt   = 2'd0;
					nxt.high_unit = 16'd0;
				end
				default: begin
					do_err   = 1'b1;
					err_code = ERR_BAD_ESC;
				end
			endcase
		end

		// string closes: completion or error, back to idle
		if (done) begin
			grp = push_result(grp, 8'd0, KIND_COMPLETE, ERR_NONE);
			nxt = IdleState;
		end else if (do_err) begin
			grp = push_result(grp, 8'd0, KIND_ERROR, err_code);
			nxt = IdleState;
		end

		// flag the final result of the run
		if (grp.count != '0) begin
			grp.item[grp.count[IdxW-1:0] - IdxW'(1)].last_of_run = 1'b1;
		end

		state_nxt = nxt;
		group     = grp;
	end

endmodule

// ===== sv/jsu_result_buf.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper: result buffer
// Holds the result group of one request and hands it out one item a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_assert.svh"

module jsu_result_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  jsu_pkg::result_group_t group,
	output logic                   free,
	jsu_result_if.source           result
);
	import jsu_pkg::*;

	result_group_t   group_s2;
	logic            valid_s2;
	logic [IdxW-1:0] idx_q;
	logic            last_idx;

	// current item and drain status
	always_comb begin
		last_idx       = (CountW'(idx_q) == group_s2.count - CountW'(1));
		result.valid   = valid_s2;
		result.payload = group_s2.item[idx_q];
		free           = !valid_s2 || (result.ready && last_idx);
	end

	// group payload
	always_ff @(posedge clk) begin
		if (load) begin
			group_s2 <= group;
		end
	end

	// occupancy and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (valid_s2 && result.ready) begin
			if (last_idx) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + IdxW'(1);
			end
		end
	end

	`JSU_ASSERT_IMPL(a_load_when_free, clk, arst_n, load, free, "group loaded over a busy buffer")
	`JSU_ASSERT_IMPL(a_load_nonempty, clk, arst_n, load, (group.count != '0) && (group.count <= CountW'(MaxResults)), "group size out of range")
	`JSU_ASSERT_IMPL(a_idx_in_group, clk, arst_n, valid_s2, CountW'(idx_q) < group_s2.count, "read index past group end")
	`JSU_ASSERT_IMPL(a_last_flag, clk, arst_n, valid_s2, result.payload.last_of_run == last_idx, "last flag not on final item")

endmodule

// ===== sv/json_string_unescape_utf8.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper, UTF-8 output
// Takes a JSON string literal one byte a request, starting at its opening
// quote, and gives the decoded text as UTF-8 bytes followed by a completion
// or a numbered error result. Simple escapes, \uXXXX and surrogate pairs are
// decoded; broken surrogates become U+FFFD. A text request is taken every
// cycle while each one causes at most one result and the output is ready. A
// request that causes n results (up to four: a four-byte character, or U+FFFD
// and a further result) holds the output, one item a cycle while the output
// is ready, and the next request waits in the input register meanwhile;
// requests with no result never wait on the output. From request to first
// result it passes the input register, the decoder and then the result buffer.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_assert.svh"

module json_string_unescape_utf8 (
	input  logic          clk,
	input  logic          arst_n,
	jsu_text_if.sink      text,
	jsu_result_if.source  result
);
	import jsu_pkg::*;

	logic          valid_s1;
	text_item_t    item_s1;
	decode_state_t state_q;
	decode_state_t state_nxt;
	result_group_t group;
	logic          buf_free;
	logic          has_results;
	logic          advance_s1;

	// request moves on when its results, if any, fit in the buffer
	always_comb begin
		has_results = (group.count != '0);
		advance_s1  = valid_s1 && (!has_results || buf_free);
		text.ready  = !valid_s1 || advance_s1;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			item_s1 <= text.payload;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IdleState;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	jsu_decode u_decode (
		.state     (state_q),
		.item      (item_s1),
		.state_nxt (state_nxt),
		.group     (group)
	);

	jsu_result_buf u_result_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance_s1 && has_results),
		.group  (group),
		.free   (buf_free),
		.result (result)
	);

	`JSU_ASSERT_NEXT(a_end_goes_idle, clk, arst_n, advance_s1 && item_s1.end_of_text, state_q.mode == MODE_IDLE, "end of text did not return to idle")
	`JSU_ASSERT_NEXT(a_stall_holds, clk, arst_n, valid_s1 && !advance_s1, valid_s1 && $stable(item_s1), "stalled request lost")
	`JSU_ASSERT_IMPL(a_idle_clean, clk, arst_n, state_q.mode == MODE_IDLE, state_q.hex_cnt == 2'd0, "hex count left over in idle")

endmodule

// ===== test/json_string_unescape_utf8_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON string unescaper: result checker
// Watches the text and result channels. Every accepted text request is run
// through a local decoder that yields the UTF-8 bytes, completion or error it
// should cause. Accepted results are compared field by field, in order,
// against that store.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_checker (
	input  logic   clk,
	input  logic   arst_n,
	jsu_text_if    text,
	jsu_result_if  result,
	output int     fail_count,
	output int     pending,
	output int     checked,
	output int     completes,
	output int     errors_seen
);
	import jsu_pkg::*;

	// local decoder state
	mode_t        dec_mode;
	logic [1:0]   digit_cnt;
	logic [15:0]  first_unit;
	logic [15:0]  second_unit;

	// results of the request being decoded, then all results still owed
	result_item_t run_q[$];
	result_item_t decoded_q[$];

	int n_fail     = 0;
	int n_checked  = 0;
	int n_complete = 0;
	int n_error    = 0;

	function automatic void put(input logic [7:0] b, input logic [1:0] kind,
		input logic [2:0] code);
		result_item_t r;
		r.out_byte    = b;
		r.result_kind = kind;
		r.error_code  = code;
		r.last_of_run = 1'b0;
		run_q = {run_q, r};
	endfunction

	function automatic void go_idle();
		dec_mode    = MODE_IDLE;
		digit_cnt   = 2'd0;
		first_unit  = 16'd0;
		second_unit = 16'd0;
	endfunction

	function automatic void put_error(input logic [2:0] code);
		go_idle();
		put(8'h00, KIND_ERROR, code);
	endfunction

	// UTF-8 encoding of one code point
	function automatic void put_code_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			put(cp[7:0], KIND_DATA, ERR_NONE);
		end else if (cp < 21'h800) begin
			put({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
			put({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
		end else if (cp < CP_SUPP) begin
			put({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
			put({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
			put({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
		end else begin
			put({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
			put({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
			put({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
			put({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
		end
	endfunction

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= CHR_0 && c <= CHR_9) return int'(c - CHR_0);
		if (c >= CHR_LA && c <= CHR_LF_HEX) return int'(c - CHR_LA) + 10;
		if (c >= CHR_UA && c <= CHR_UF) return int'(c - CHR_UA) + 10;
		return -1;
	endfunction

	// counts one hex digit; true once the fourth has been taken
	function automatic logic unit_complete();
		if (digit_cnt == 2'd3) begin
			digit_cnt = 2'd0;
			return 1'b1;
		end
		digit_cnt = digit_cnt + 2'd1;
		return 1'b0;
	endfunction

	function automatic void take_string_byte(input logic [7:0] b);
		dec_mode = MODE_STR;
		if (b == CHR_QUOTE) begin
			go_idle();
			put(8'h00, KIND_COMPLETE, ERR_NONE);
		end else if (b == CHR_BSLASH) begin
			dec_mode = MODE_ESC;
		end else if (b < CHR_SPACE) begin
			put_error(ERR_CONTROL);
		end else begin
			put(b, KIND_DATA, ERR_NONE);
		end
	endfunction

	function automatic void take_escape_byte(input logic [7:0] b);
		dec_mode = MODE_STR;
		case (b)
			CHR_QUOTE, CHR_BSLASH, CHR_SLASH: put(b, KIND_DATA, ERR_NONE);
			CHR_B: put(CHR_BS, KIND_DATA, ERR_NONE);
			CHR_F: put(CHR_FF, KIND_DATA, ERR_NONE);
			CHR_N: put(CHR_LF, KIND_DATA, ERR_NONE);
			CHR_R: put(CHR_CR, KIND_DATA, ERR_NONE);
			CHR_T: put(CHR_TAB, KIND_DATA, ERR_NONE);
			CHR_U: begin
				dec_mode   = MODE_HEX_HI;
				digit_cnt  = 2'd0;
				first_unit = 16'd0;
			end
			default: put_error(ERR_BAD_ESC);
		endcase
	endfunction

	// decodes one text request and files the results it should cause
	function automatic void decode_request(input text_item_t t);
		int          nib;
		logic [7:0]  b;
		b = t.in_byte;
		run_q.delete();
		if (t.end_of_text) begin
			case (dec_mode)
				MODE_STR:                 put_error(ERR_UNTERMINATED);
				MODE_ESC:                 put_error(ERR_UNTERM_ESC);
				MODE_HEX_HI, MODE_HEX_LO: put_error(ERR_TRUNC_HEX);
				MODE_AFT_HI: begin
					put_code_point(CP_REPLACE);
					put_error(ERR_UNTERMINATED);
				end
				MODE_AFT_HI_BS: begin
					put_code_point(CP_REPLACE);
					put_error(ERR_UNTERM_ESC);
				end
				default: put_error(ERR_EXP_QUOTE);
			endcase
		end else begin
			case (dec_mode)
				MODE_STR: take_string_byte(b);
				MODE_ESC: take_escape_byte(b);
				MODE_HEX_HI: begin
					nib = hex_nibble(b);
					if (nib < 0) begin
						put_error(ERR_BAD_HEX);
					end else begin
						first_unit = {first_unit[11:0], 4'(nib)};
						if (unit_complete()) begin
							dec_mode = MODE_STR;
							if (first_unit inside {[SURR_HI_MIN:SURR_HI_MAX]})
								dec_mode = MODE_AFT_HI;
							else if (first_unit inside {[SURR_LO_MIN:SURR_LO_MAX]})
								put_code_point(CP_REPLACE);
							else
								put_code_point({5'd0, first_unit});
						end
					end
				end
				// high surrogate seen: only a backslash keeps the pair alive
				MODE_AFT_HI: begin
					if (b == CHR_BSLASH) begin
						dec_mode = MODE_AFT_HI_BS;
					end else begin
						put_code_point(CP_REPLACE);
						take_string_byte(b);
					end
				end
				MODE_AFT_HI_BS: begin
					if (b == CHR_U) begin
						dec_mode    = MODE_HEX_LO;
						digit_cnt   = 2'd0;
						second_unit = 16'd0;
					end else begin
						put_code_point(CP_REPLACE);
						take_escape_byte(b);
					end
				end
				MODE_HEX_LO: begin
					nib = hex_nibble(b);
					if (nib < 0) begin
						put_error(ERR_BAD_HEX);
					end else begin
						second_unit = {second_unit[11:0], 4'(nib)};
						if (unit_complete()) begin
							dec_mode = MODE_STR;
							// surrogate bases have ten clear low bits
							if (second_unit inside {[SURR_LO_MIN:SURR_LO_MAX]})
								put_code_point(CP_SUPP +
									{1'b0, first_unit[9:0], second_unit[9:0]});
							else
								put_code_point(CP_REPLACE);
						end
					end
				end
				default: begin
					if (b == CHR_QUOTE) begin
						dec_mode  = MODE_STR;
						digit_cnt = 2'd0;
					end else begin
						put_error(ERR_EXP_QUOTE);
					end
				end
			endcase
		end
		if (run_q.size() > 0) run_q[run_q.size() - 1].last_of_run = 1'b1;
		foreach (run_q[i]) decoded_q = {decoded_q, run_q[i]};
	endfunction

	function automatic void cmp_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_fail++;
		end
	endfunction

	function automatic void check_result(input result_item_t got);
		result_item_t want;
		if (decoded_q.size() == 0) begin
			$error("unexpected result: out_byte %0h kind %0d code %0d last %0b",
				got.out_byte, got.result_kind, got.error_code, got.last_of_run);
			n_fail++;
		end else begin
			want = decoded_q.pop_front();
			n_checked++;
			cmp_field("out_byte", want.out_byte, got.out_byte);
			cmp_field("result_kind", want.result_kind, got.result_kind);
			cmp_field("error_code", want.error_code, got.error_code);
			cmp_field("last_of_run", want.last_of_run, got.last_of_run);
			if (want.result_kind == KIND_COMPLETE) n_complete++;
			if (want.result_kind == KIND_ERROR) n_error++;
		end
	endfunction

	// results leave the block only after their request has passed the input register
	// and the result buffer, so checking before decoding at the same edge is safe
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_idle();
			decoded_q.delete();
			pending <= 0;
		end else begin
			if (result.valid && result.ready) check_result(result.payload);
			if (text.valid && text.ready) decode_request(text.payload);
			pending <= decoded_q.size();
		end
		fail_count  <= n_fail;
		checked     <= n_checked;
		completes   <= n_complete;
		errors_seen <= n_error;
	end

endmodule

// ===== test/json_string_unescape_utf8_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON string unescaper: testbench
// Sends a short directed set of strings, then random string literals built
// from plain bytes, escapes, \u units and whole or broken surrogate pairs,
// ended by a quote or by one of the error conditions. The sender works in
// bursts and the receiver stalls on a changing pattern; a separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;
	import jsu_pkg::*;

	localparam int RandomRequests = 370;
	localparam int CycleLimit     = 200000;
	localparam int SettleCycles   = 8;

	logic clk;
	logic arst_n;

	jsu_text_if   text_ch();
	jsu_result_if result_ch();

	int fail_count;
	int pending;
	int checked;
	int completes;
	int errors_seen;

	int sent       = 0;
	int burst_left = 0;
	int rx_cycle   = 0;
	int cycle_count;
	int directed_count;

	logic [7:0] simple_esc [8] = '{CHR_QUOTE, CHR_BSLASH, CHR_SLASH, CHR_B,
		CHR_F, CHR_N, CHR_R, CHR_T};

	json_string_unescape_utf8 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch)
	);

	json_string_unescape_utf8_checker decode_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text_ch),
		.result      (result_ch),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked),
		.completes   (completes),
		.errors_seen (errors_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped after %0d cycles", CycleLimit);
		$display("== FAIL ==");
		$finish;
	end

	// receiver: ready pattern is chosen by bits 9:8 of rx_cycle
	always @(negedge clk) begin
		rx_cycle++;
		case (rx_cycle[9:8])
			2'd0: result_ch.ready = 1'b1;
			2'd1: result_ch.ready = ($urandom_range(0, 99) >= 35);
			2'd2: result_ch.ready = ((rx_cycle % 5) < 2);
			default: result_ch.ready = rx_cycle[2];
		endcase
	end

	// one text request; entered just after a falling edge
	task automatic send_request(input logic [7:0] b, input logic eot);
		int gap;
		if (burst_left == 0) begin
			text_ch.valid = 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		text_ch.payload.in_byte     = b;
		text_ch.payload.end_of_text = eot;
		text_ch.valid               = 1'b1;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_request(b, 1'b0);
	endtask

	// byte lane is ignored with the end marker, so fill it at random
	task automatic send_end();
		send_request(8'($urandom), 1'b1);
	endtask

	// first k hex digits of a unit, upper or lower case at random
	task automatic send_hex_digits(input logic [15:0] u, input int k);
		logic [3:0] nib;
		logic [7:0] ch;
		for (int i = 3; i > 3 - k; i--) begin
			nib = u[i*4 +: 4];
			if (nib < 4'd10)
				ch = CHR_0 + 8'(nib);
			else
				ch = ($urandom_range(0, 1) ? CHR_UA : CHR_LA) + 8'(nib) - 8'd10;
			send_byte(ch);
		end
	endtask

	task automatic send_unit(input logic [15:0] u);
		send_byte(CHR_BSLASH);
		send_byte(CHR_U);
		send_hex_digits(u, 4);
	endtask

	function automatic logic [15:0] high_surrogate();
		return SURR_HI_MIN | 16'($urandom_range(0, 16'h3FF));
	endfunction

	function automatic logic [15:0] low_surrogate();
		return SURR_LO_MIN | 16'($urandom_range(0, 16'h3FF));
	endfunction

	function automatic logic [7:0] non_hex_byte();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(8'h67, 8'h7A));
			1: return 8'($urandom_range(8'h80, 8'hFF));
			2: return 8'($urandom_range(8'h00, 8'h2F));
			default: return 8'($urandom_range(8'h47, 8'h5A));
		endcase
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(8'h20, 8'hFF));
		while (b == CHR_QUOTE || b == CHR_BSLASH);
		return b;
	endfunction

	// one piece of string body; a lone high surrogate lets the next piece
	// or the ending decide how the pair breaks
	task automatic send_piece();
		logic [15:0] u;
		case ($urandom_range(0, 9))
			3: begin
				send_byte(CHR_BSLASH);
				send_byte(simple_esc[$urandom_range(0, 7)]);
			end
			4, 5: begin
				case ($urandom_range(0, 2))
					0: u = 16'($urandom_range(0, 16'h7F));
					1: u = 16'($urandom_range(16'h80, 16'h7FF));
					default: u = 16'($urandom_range(16'h800, 16'hFFFF));
				endcase
				send_unit(u);
			end
			6: begin
				send_unit(high_surrogate());
				send_unit(low_surrogate());
			end
			7: send_unit(high_surrogate());
			8: send_unit(low_surrogate());
			default: send_byte(plain_byte());
		endcase
	endtask

	// closing quote mostly, otherwise one of the error endings
	task automatic send_ending();
		logic [7:0] b;
		case ($urandom_range(0, 19))
			13: send_end();
			14: send_byte(8'($urandom_range(0, 8'h1F)));
			15: begin
				do b = 8'($urandom);
				while (b inside {CHR_QUOTE, CHR_BSLASH, CHR_SLASH, CHR_B, CHR_F,
					CHR_N, CHR_R, CHR_T, CHR_U});
				send_byte(CHR_BSLASH);
				send_byte(b);
			end
			16: begin
				send_byte(CHR_BSLASH);
				send_end();
			end
			17, 18: begin
				// cut short or broken hex, in the first or the second unit
				if ($urandom_range(0, 1)) send_unit(high_surrogate());
				send_byte(CHR_BSLASH);
				send_byte(CHR_U);
				send_hex_digits(16'($urandom), $urandom_range(0, 3));
				if ($urandom_range(0, 1))
					send_end();
				else
					send_byte(non_hex_byte());
			end
			19: begin
				send_unit(high_surrogate());
				send_byte(CHR_BSLASH);
				send_end();
			end
			default: send_byte(CHR_QUOTE);
		endcase
	endtask

	// stop sending until every result owed has arrived
	task automatic wait_drained();
		text_ch.valid = 1'b0;
		burst_left    = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [7:0] b;
		int pieces;
		arst_n              = 1'b0;
		text_ch.valid       = 1'b0;
		text_ch.payload     = '0;
		result_ch.ready     = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: idle errors, control, byte extremes, bad escape,
		// end after backslash, lone high surrogate at end, bad hex digit
		send_byte("x");
		send_end();
		send_byte(CHR_QUOTE);
		send_byte(8'h00);
		send_byte(CHR_QUOTE);
		send_byte(8'h20);
		send_byte(8'hFF);
		send_byte(CHR_BSLASH);
		send_byte("q");
		send_byte(CHR_QUOTE);
		send_byte(CHR_BSLASH);
		send_end();
		send_byte(CHR_QUOTE);
		send_unit(16'hD800);
		send_end();
		send_byte(CHR_QUOTE);
		send_byte(CHR_BSLASH);
		send_byte(CHR_U);
		send_byte(CHR_0);
		send_byte("g");
		wait_drained();
		directed_count = sent;

		// random strings with some noise between them
		while (sent < directed_count + RandomRequests) begin
			if ($urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 1)) begin
					do b = 8'($urandom);
					while (b == CHR_QUOTE);
					send_byte(b);
				end else begin
					send_end();
				end
			end
			send_byte(CHR_QUOTE);
			pieces = $urandom_range(0, 6);
			repeat (pieces) send_piece();
			send_ending();
			if ($urandom_range(0, 14) == 0) wait_drained();
		end

		wait_drained();
		$display("%0d text requests sent, %0d results checked: %0d strings complete, %0d errors",
			sent, checked, completes, errors_seen);
		$display("escapes, hex units, surrogate pairs and broken endings ran under "
			, "bursty input and stalled output");
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
